@@ hw/rtl/itt_pkg.sv @@
// Shared types and constants for the three-channel interval timer.
// Used by itt_counter and interval_timer_three_channel_unit; no dependencies.
package itt_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned CH_COUNT   = 3;
  localparam int unsigned CH_IDX_W   = 2;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned NS_W       = 30;
  localparam int unsigned PROD_W     = TICK_W + NS_W;
  localparam int unsigned SCALED_W   = PROD_W - (TICK_W - FRAC_BITS);
  localparam int unsigned DELTA_W    = FRAC_BITS + 23;
  localparam int unsigned COUNT_W    = FRAC_BITS + 24;
  localparam int unsigned RELOAD_W   = 17;
  localparam int unsigned LATCH_W    = 16;

  localparam logic [TICK_W-1:0]   TICK_RESET   = 32'd5116087;
  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 17'h10000;
  localparam logic [DELTA_W-1:0]  DELTA_MAX    = DELTA_W'(1) << (FRAC_BITS + 22);
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(RELOAD_RESET) << FRAC_BITS;

  localparam logic [1:0] PORT_CMD  = 2'd3;
  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LOHI  = 2'd3;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  typedef struct packed {
    logic               wr_en;
    logic [7:0]         wdata;
    logic               adv_en;
    logic [DELTA_W-1:0] delta;
  } chan_ctrl_t;

  typedef struct packed {
    logic [LATCH_W-1:0] latch;
    logic               underflow;
  } chan_stat_t;

endpackage

@@ hw/rtl/itt_counter.sv @@
// One timer channel: divisor staging, reload value and fractional down-counter.
// Depends on itt_pkg.
module itt_counter
  import itt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chan_ctrl_t ctrl_i,
  output chan_stat_t stat_o
);

  localparam logic signed [COUNT_W:0] COUNT_FLOOR = -((COUNT_W+1)'(1) << (COUNT_W - 1));

  logic [15:0]           staging_q, staging_d;
  logic                  hi_next_q, hi_next_d;
  logic [RELOAD_W-1:0]   reload_q, reload_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic signed [COUNT_W:0] diff;
  logic signed [COUNT_W:0] diff_sat;
  logic [COUNT_W-LATCH_W-FRAC_BITS-1:0] whole_hi;
  logic                  underflow;

  always_comb begin
    staging_d = staging_q;
    hi_next_d = hi_next_q;
    reload_d  = reload_q;
    count_d   = count_q;
    underflow = 1'b0;
    diff      = $signed({count_q[COUNT_W-1], count_q}) - $signed({2'b00, ctrl_i.delta});
    diff_sat  = (diff < COUNT_FLOOR) ? COUNT_FLOOR : diff;
    if (ctrl_i.wr_en) begin
      if (!hi_next_q) begin
        staging_d = {staging_q[15:8], ctrl_i.wdata};
        hi_next_d = 1'b1;
      end else begin
        staging_d = {ctrl_i.wdata, staging_q[7:0]};
        hi_next_d = 1'b0;
        reload_d  = (staging_d == 16'd0) ? RELOAD_RESET : {1'b0, staging_d};
        count_d   = COUNT_W'(reload_d) << FRAC_BITS;
      end
    end else if (ctrl_i.adv_en) begin
      if (diff_sat[COUNT_W]) begin
        count_d   = diff_sat[COUNT_W-1:0] + (COUNT_W'(reload_q) << FRAC_BITS);
        underflow = 1'b1;
      end else begin
        count_d = diff_sat[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staging_q <= '0;
      hi_next_q <= 1'b0;
      reload_q  <= RELOAD_RESET;
      count_q   <= COUNT_RESET;
    end else begin
      staging_q <= staging_d;
      hi_next_q <= hi_next_d;
      reload_q  <= reload_d;
      count_q   <= count_d;
    end
  end

  // saturate the whole part to 0..65535
  assign whole_hi = count_q[COUNT_W-2:LATCH_W+FRAC_BITS];

  always_comb begin
    if (count_q[COUNT_W-1]) begin
      stat_o.latch = '0;
    end else if (whole_hi != '0) begin
      stat_o.latch = '1;
    end else begin
      stat_o.latch = count_q[LATCH_W+FRAC_BITS-1:FRAC_BITS];
    end
    stat_o.underflow = underflow;
  end

endmodule

@@ hw/rtl/interval_timer_three_channel_unit.sv @@
// Three-channel interval timer: bus port reads/writes and time advance items.
// Depends on itt_pkg and itt_counter.
// Pipeline: the scaled tick product is registered in the input stage with the item;
// state is updated and the result registered in the second stage, which holds while
// results stall.
// Throughput: one item per cycle while results are taken; the counters are read
// and written in a single stage. Reset: counters at 65536 ticks, rate 5116087.
module interval_timer_three_channel_unit
  import itt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TICK_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [1:0]        port_i,
  input  logic [7:0]        write_data_i,
  input  logic [NS_W-1:0]   elapsed_ns_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        read_data_o,
  output logic              timer_irq_o
);

  logic [TICK_W-1:0]   tick_rate_q;
  logic                s1_valid_q;
  logic [1:0]          s1_op_q;
  logic [1:0]          s1_port_q;
  logic [7:0]          s1_data_q;
  logic [DELTA_W-1:0]  s1_delta_q, s1_delta_d;
  logic                out_valid_q;
  logic [7:0]          read_data_q, read_data_d;
  logic                timer_irq_q, timer_irq_d;
  logic [7:0]          command_q, command_d;
  logic [LATCH_W-1:0]  latch_q, latch_d;
  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] scaled;
  logic                out_free, s1_fire, in_fire;
  chan_ctrl_t          ctrl [CH_COUNT];
  chan_stat_t          stat [CH_COUNT];

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_fire     = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;
  assign in_fire     = in_valid_i && in_ready_o;

  // scale elapsed time by the tick rate, saturate
  assign prod   = PROD_W'(tick_rate_q) * PROD_W'(elapsed_ns_i);
  assign scaled = prod[PROD_W-1:TICK_W-FRAC_BITS];
  assign s1_delta_d = (scaled > SCALED_W'(DELTA_MAX)) ? DELTA_MAX : scaled[DELTA_W-1:0];

  always_comb begin
    command_d   = command_q;
    latch_d     = latch_q;
    read_data_d = 8'd0;
    timer_irq_d = 1'b0;
    for (int unsigned i = 0; i < CH_COUNT; i++) begin
      ctrl[i].wr_en  = 1'b0;
      ctrl[i].wdata  = s1_data_q;
      ctrl[i].adv_en = 1'b0;
      ctrl[i].delta  = s1_delta_q;
    end
    if (s1_fire) begin
      case (op_e'(s1_op_q))
        OP_READ: begin
          read_data_d = latch_q[7:0];
          latch_d     = {8'd0, latch_q[LATCH_W-1:8]};
        end
        OP_WRITE: begin
          if (s1_port_q == PORT_CMD) begin
            command_d = s1_data_q;
            if (s1_data_q[5:4] == ACC_LATCH) begin
              for (int unsigned i = 0; i < CH_COUNT; i++) begin
                if (s1_data_q[7:6] == CH_IDX_W'(i)) begin
                  latch_d = stat[i].latch;
                end
              end
            end
          end else if (command_q[5:4] == ACC_LOHI) begin
            for (int unsigned i = 0; i < CH_COUNT; i++) begin
              ctrl[i].wr_en = (s1_port_q == CH_IDX_W'(i));
            end
          end
        end
        OP_ADVANCE: begin
          // channel 1 never advances
          for (int unsigned i = 0; i < CH_COUNT; i++) begin
            ctrl[i].adv_en = (i == 0) || (i == 2);
          end
          timer_irq_d = stat[0].underflow;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < CH_COUNT; g++) begin : g_chan
    itt_counter u_counter (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[g]),
      .stat_o (stat[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= TICK_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      command_q   <= '0;
      latch_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        tick_rate_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      command_q <= command_d;
      latch_q   <= latch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= operation_i;
      s1_port_q  <= port_i;
      s1_data_q  <= write_data_i;
      s1_delta_q <= s1_delta_d;
    end
    if (s1_fire) begin
      read_data_q <= read_data_d;
      timer_irq_q <= timer_irq_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign timer_irq_o = timer_irq_q;

endmodule

@@ verif/interval_timer_three_channel_checker.sv @@
// Checker for the three-channel interval timer: watches the config, item and result
// channels, predicts each result from its own copy of the timer state and compares.
// Depends on itt_pkg.
module interval_timer_three_channel_checker
  import itt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [TICK_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        operation_i,
  input  logic [1:0]        port_i,
  input  logic [7:0]        write_data_i,
  input  logic [NS_W-1:0]   elapsed_ns_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        read_data_i,
  input  logic              timer_irq_i,
  output int                outstanding_o,
  output int                mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint COUNT_FLOOR = -(longint'(1) << (FRAC_BITS + 23));

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } bus_result_t;

  bus_result_t awaited_results[$];
  int          mismatches = 0;
  int          results_seen = 0;

  logic [TICK_W-1:0]         rate_q;
  logic [7:0]                cmd_q;
  logic [LATCH_W-1:0]        latch_q;
  logic [15:0]               staging_q [CH_COUNT];
  logic                      hi_next_q [CH_COUNT];
  logic [RELOAD_W-1:0]       reload_q  [CH_COUNT];
  logic signed [COUNT_W-1:0] count_q   [CH_COUNT];

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at result %0d: %s got %0h expected %0h", results_seen, what, got,
             want);
    mismatches++;
  endtask

  task automatic reset_timer_state();
    rate_q  = TICK_RESET;
    cmd_q   = '0;
    latch_q = '0;
    for (int c = 0; c < CH_COUNT; c++) begin
      staging_q[c] = '0;
      hi_next_q[c] = 1'b0;
      reload_q[c]  = RELOAD_RESET;
      count_q[c]   = COUNT_RESET;
    end
  endtask

  function automatic logic [LATCH_W-1:0] latch_of(input logic signed [COUNT_W-1:0] cnt);
    logic signed [COUNT_W-1:0] whole;
    whole = cnt >>> FRAC_BITS;
    if (cnt < 0) return '0;
    if (whole > 65535) return '1;
    return whole[LATCH_W-1:0];
  endfunction

  task automatic advance_channel(input int ch, input logic [63:0] delta, output bit wrapped);
    longint nxt;
    nxt = longint'(count_q[ch]) - longint'(delta);
    if (nxt < COUNT_FLOOR) nxt = COUNT_FLOOR;
    wrapped = (nxt < 0);
    if (wrapped) nxt = nxt + (longint'(reload_q[ch]) << FRAC_BITS);
    count_q[ch] = COUNT_W'(nxt);
  endtask

  task automatic predict_timer_item(input logic [1:0] op, input logic [1:0] prt,
                                    input logic [7:0] wd, input logic [NS_W-1:0] ns,
                                    output bus_result_t res);
    logic [63:0] scaled;
    logic [1:0]  ch;
    bit          wrapped;
    res = '0;
    case (op)
      OP_READ: begin
        res.read_data = latch_q[7:0];
        latch_q       = latch_q >> 8;
      end
      OP_WRITE: begin
        if (prt == PORT_CMD) begin
          cmd_q = wd;
          ch    = wd[7:6];
          if (wd[5:4] == ACC_LATCH && ch < CH_COUNT) latch_q = latch_of(count_q[ch]);
        end else if (cmd_q[5:4] == ACC_LOHI && prt < CH_COUNT) begin
          if (!hi_next_q[prt]) begin
            staging_q[prt][7:0] = wd;
            hi_next_q[prt]      = 1'b1;
          end else begin
            staging_q[prt][15:8] = wd;
            hi_next_q[prt]       = 1'b0;
            reload_q[prt] = (staging_q[prt] == '0) ? RELOAD_RESET : RELOAD_W'(staging_q[prt]);
            count_q[prt]  = COUNT_W'(reload_q[prt]) << FRAC_BITS;
          end
        end
      end
      OP_ADVANCE: begin
        scaled = (64'(rate_q) * 64'(ns)) >> (TICK_W - FRAC_BITS);
        if (scaled > 64'(DELTA_MAX)) scaled = 64'(DELTA_MAX);
        advance_channel(0, scaled, wrapped);
        res.timer_irq = wrapped;
        if (CH_COUNT > 2) advance_channel(2, scaled, wrapped);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bus_result_t want;
    bus_result_t got;
    if (!rst_ni) begin
      reset_timer_state();
      awaited_results.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing awaited", read_data_i, 0);
        end else begin
          want = awaited_results.pop_front();
          got  = '{read_data: read_data_i, timer_irq: timer_irq_i};
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.timer_irq !== want.timer_irq)
            report_mismatch("timer_irq", got.timer_irq, want.timer_irq);
        end
      end
      if (cfg_valid_i && cfg_ready_i) rate_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        predict_timer_item(operation_i, port_i, write_data_i, elapsed_ns_i, want);
        awaited_results.push_back(want);
      end
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

@@ verif/interval_timer_three_channel_unit_tb.sv @@
// Testbench top for interval_timer_three_channel_unit: drives directed and random
// bus and time items across several tick rates, with bursty input and stalling output.
// Depends on itt_pkg, the unit and interval_timer_three_channel_checker.
module interval_timer_three_channel_unit_tb;
  import itt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE       = 2'd3;
  localparam logic [1:0] ACC_LSB_ONLY  = 2'd1;
  localparam int         PHASES        = 6;
  localparam int         PHASE_ITEMS   = 125;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         WATCHDOG_LIMIT = 4000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [TICK_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        operation_i;
  logic [1:0]        port_i;
  logic [7:0]        write_data_i;
  logic [NS_W-1:0]   elapsed_ns_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [7:0]        read_data_o;
  logic              timer_irq_o;

  int outstanding;
  int mismatches;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit hold_off_req = 1'b0;

  interval_timer_three_channel_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .port_i       (port_i),
    .write_data_i (write_data_i),
    .elapsed_ns_i (elapsed_ns_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .timer_irq_o  (timer_irq_o)
  );

  interval_timer_three_channel_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .operation_i   (operation_i),
    .port_i        (port_i),
    .write_data_i  (write_data_i),
    .elapsed_ns_i  (elapsed_ns_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_i   (read_data_o),
    .timer_irq_i   (timer_irq_o),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stall pattern of its own, plus one long hold-off on request
  initial begin : result_sink
    int stall_mode;
    int mode_left;
    stall_mode = 0;
    mode_left  = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(8, 64);
        end
        mode_left--;
        case (stall_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [NS_W-1:0] pick_elapsed();
    case ($urandom_range(0, 3))
      0:       return NS_W'($urandom_range(0, 64));
      1:       return NS_W'($urandom_range(0, 100000));
      2:       return NS_W'($urandom_range(0, 1000000000));
      default: return NS_W'($urandom());
    endcase
  endfunction

  task automatic put_item(input logic [1:0] op, input logic [1:0] prt,
                          input logic [7:0] wd, input logic [NS_W-1:0] ns);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    port_i       <= prt;
    write_data_i <= wd;
    elapsed_ns_i <= ns;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_tick_rate(input logic [TICK_W-1:0] rate);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= rate;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_sequence();
    int          pick;
    logic [1:0]  ch;
    logic [15:0] div;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      ch = 2'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0:       div = '0;
        1:       div = 16'($urandom());
        default: div = 16'($urandom_range(1, 64));
      endcase
      put_item(OP_WRITE, PORT_CMD, {ch, ACC_LOHI, 4'($urandom())}, pick_elapsed());
      put_item(OP_WRITE, ch, div[7:0], pick_elapsed());
      put_item(OP_WRITE, ch, div[15:8], pick_elapsed());
    end else if (pick < 55) begin
      put_item(OP_WRITE, PORT_CMD, {2'($urandom()), ACC_LATCH, 4'($urandom())},
               pick_elapsed());
      repeat ($urandom_range(1, 3))
        put_item(OP_READ, 2'($urandom()), 8'($urandom()), pick_elapsed());
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 4))
        put_item(OP_ADVANCE, 2'($urandom()), 8'($urandom()), pick_elapsed());
    end else begin
      put_item(2'($urandom()), 2'($urandom()), 8'($urandom()), NS_W'($urandom()));
    end
  endtask

  initial begin : stimulus
    int                target;
    logic [TICK_W-1:0] rate;
    rst_ni       = 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    operation_i  <= OP_READ;
    port_i       <= '0;
    write_data_i <= '0;
    elapsed_ns_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put_item(OP_READ, 2'd0, 8'h00, '0);
    put_item(OP_READ, PORT_CMD, 8'hFF, '1);
    put_item(OP_WRITE, PORT_CMD, {2'd0, ACC_LATCH, 4'h0}, '0);
    put_item(OP_READ, 2'd0, 8'h00, '0);
    put_item(OP_READ, 2'd1, 8'h00, '0);
    put_item(OP_WRITE, PORT_CMD, {2'd3, ACC_LATCH, 4'hF}, '0);
    put_item(OP_READ, 2'd2, 8'h00, '0);
    put_item(OP_WRITE, PORT_CMD, {2'd1, ACC_LOHI, 4'h0}, '0);
    put_item(OP_WRITE, 2'd1, 8'h34, '0);
    put_item(OP_WRITE, 2'd1, 8'h12, '0);
    put_item(OP_WRITE, PORT_CMD, {2'd1, ACC_LATCH, 4'h0}, '0);
    put_item(OP_READ, 2'd1, 8'h00, '0);
    put_item(OP_READ, 2'd1, 8'h00, '0);
    put_item(OP_WRITE, PORT_CMD, {2'd0, ACC_LSB_ONLY, 4'h0}, '0);
    put_item(OP_WRITE, 2'd0, 8'hAA, '0);
    put_item(OP_WRITE, PORT_CMD, {2'd2, ACC_LOHI, 4'h0}, '0);
    put_item(OP_WRITE, 2'd2, 8'h05, '0);
    put_item(OP_WRITE, 2'd2, 8'h00, '0);
    put_item(OP_WRITE, 2'd0, 8'h00, '0);
    put_item(OP_WRITE, 2'd0, 8'h00, '0);
    put_item(OP_ADVANCE, 2'd0, 8'h00, '0);
    put_item(OP_ADVANCE, 2'd0, 8'h00, NS_W'(1000));
    put_item(OP_ADVANCE, 2'd0, 8'h00, NS_W'(1000000000));
    put_item(OP_ADVANCE, 2'd3, 8'hFF, '1);
    put_item(OP_ADVANCE, 2'd3, 8'hFF, '1);
    put_item(OP_NONE, PORT_CMD, 8'hFF, '1);
    put_item(OP_WRITE, PORT_CMD, {2'd2, ACC_LATCH, 4'h0}, '0);
    put_item(OP_READ, 2'd2, 8'h00, '0);
    put_item(OP_READ, 2'd2, 8'h00, '0);

    target = items_sent;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       rate = '1;
        1:       rate = 32'd1;
        2:       rate = 32'($urandom_range(1, 32'h0010_0000));
        3:       rate = TICK_RESET;
        default: rate = 32'($urandom_range(1, 32'hFFFF_FFFF));
      endcase
      write_tick_rate(rate);
      if (phase == 3) hold_off_req = 1'b1;
      target += PHASE_ITEMS;
      while (items_sent < target) random_sequence();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/itt_pkg.sv
hw/rtl/itt_counter.sv
hw/rtl/interval_timer_three_channel_unit.sv
verif/interval_timer_three_channel_checker.sv
verif/interval_timer_three_channel_unit_tb.sv
